[rtl/wsfr_pkg.sv]
// ============================================================================
// wsfr_pkg
// Shared types and constants of the WebSocket frame receiver.
// ============================================================================
package wsfr_pkg;

    localparam int QueueDepth = 4;
    localparam logic [15:0] MaxPayloadReset = 16'd1023;

    localparam logic [3:0] OpcClose = 4'h8;
    localparam logic [3:0] OpcPing  = 4'h9;
    localparam logic [6:0] Len7Ext16 = 7'd126;
    localparam logic [6:0] Len7Ext64 = 7'd127;

    typedef enum logic [2:0] {
        EV_DATA       = 3'd0,
        EV_PING       = 3'd1,
        EV_EMPTY_DATA = 3'd2,
        EV_EMPTY_PING = 3'd3,
        EV_CLOSE      = 3'd4,
        EV_OVERSIZE   = 3'd5
    } t_event;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] payload_byte;
        logic [3:0] frame_opcode;
        logic       last;
    } t_result;

endpackage

[rtl/wsfr_front.sv]
// ============================================================================
// wsfr_front
// Header parser and payload unmasker: classifies each received byte and
// pushes at most one result per byte into the result queue.
// ============================================================================
module wsfr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_byte_valid,
    input  logic [7:0]        i_byte,
    output logic              o_push,
    output wsfr_pkg::t_result o_res
);
    import wsfr_pkg::*;

    typedef enum logic [5:0] {
        PH_HDR0    = 6'b000001,
        PH_HDR1    = 6'b000010,
        PH_EXT16   = 6'b000100,
        PH_EXT64   = 6'b001000,
        PH_MASK    = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } t_phase;

    t_phase      r_phase,        n_phase;
    logic [3:0]  r_opcode,       n_opcode;
    logic        r_mask_present, n_mask_present;
    logic [2:0]  r_hdr_cnt,      n_hdr_cnt;
    logic [31:0] r_mask_key,     n_mask_key;
    logic [1:0]  r_mask_pos,     n_mask_pos;
    logic [63:0] r_remaining,    n_remaining;
    logic        r_dropping,     n_dropping;
    logic [15:0] r_max_payload;

    logic [63:0] w_len;
    logic        w_hdr_done;
    logic [7:0]  w_key_byte;
    logic [7:0]  w_plain;
    logic        w_last;

    always_comb begin
        case (r_mask_pos)
            2'd0:    w_key_byte = r_mask_key[31:24];
            2'd1:    w_key_byte = r_mask_key[23:16];
            2'd2:    w_key_byte = r_mask_key[15:8];
            default: w_key_byte = r_mask_key[7:0];
        endcase
    end

    assign w_plain = r_mask_present ? (i_byte ^ w_key_byte) : i_byte;
    assign w_last  = (r_remaining == 64'd1);

    always_comb begin
        n_phase        = r_phase;
        n_opcode       = r_opcode;
        n_mask_present = r_mask_present;
        n_hdr_cnt      = r_hdr_cnt;
        n_mask_key     = r_mask_key;
        n_mask_pos     = r_mask_pos;
        n_remaining    = r_remaining;
        n_dropping     = r_dropping;
        w_len          = r_remaining;
        w_hdr_done     = 1'b0;
        o_push         = 1'b0;
        o_res.event_res    = EV_DATA;
        o_res.payload_byte = 8'd0;
        o_res.frame_opcode = r_opcode;
        o_res.last         = 1'b1;

        if (i_byte_valid) begin
            case (r_phase)
                PH_HDR1: begin
                    n_mask_present = i_byte[7];
                    n_hdr_cnt      = 3'd0;
                    w_len          = {57'd0, i_byte[6:0]};
                    n_remaining    = w_len;
                    if (i_byte[6:0] == Len7Ext16) begin
                        n_phase     = PH_EXT16;
                        n_remaining = 64'd0;
                    end else if (i_byte[6:0] == Len7Ext64) begin
                        n_phase     = PH_EXT64;
                        n_remaining = 64'd0;
                    end else if (i_byte[7]) begin
                        n_phase = PH_MASK;
                    end else begin
                        n_mask_key = 32'd0;
                        w_hdr_done = 1'b1;
                    end
                end
                PH_EXT16, PH_EXT64: begin
                    w_len       = {r_remaining[55:0], i_byte};
                    n_remaining = w_len;
                    n_hdr_cnt   = r_hdr_cnt + 3'd1;
                    if ((r_phase == PH_EXT16 && n_hdr_cnt == 3'd2) ||
                        (r_phase == PH_EXT64 && n_hdr_cnt == 3'd0)) begin
                        n_hdr_cnt = 3'd0;
                        if (r_mask_present) begin
                            n_phase = PH_MASK;
                        end else begin
                            n_mask_key = 32'd0;
                            w_hdr_done = 1'b1;
                        end
                    end
                end
                PH_MASK: begin
                    n_mask_key = {r_mask_key[23:0], i_byte};
                    n_hdr_cnt  = r_hdr_cnt + 3'd1;
                    if (n_hdr_cnt >= 3'd4) begin
                        n_hdr_cnt  = 3'd0;
                        w_hdr_done = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    n_mask_pos  = r_mask_pos + 2'd1;
                    n_remaining = r_remaining - 64'd1;
                    o_res.last  = w_last;
                    if (w_last) begin
                        n_phase = PH_HDR0;
                    end
                    if (r_dropping) begin
                        if (w_last) begin
                            n_dropping      = 1'b0;
                            o_push          = 1'b1;
                            o_res.event_res = EV_OVERSIZE;
                        end
                    end else if (r_opcode == OpcClose) begin
                        o_push          = w_last;
                        o_res.event_res = EV_CLOSE;
                    end else begin
                        o_push             = 1'b1;
                        o_res.payload_byte = w_plain;
                        o_res.event_res    = (r_opcode == OpcPing) ? EV_PING : EV_DATA;
                    end
                end
                default: begin
                    n_opcode       = i_byte[3:0];
                    n_mask_present = 1'b0;
                    n_dropping     = 1'b0;
                    n_hdr_cnt      = 3'd0;
                    n_mask_pos     = 2'd0;
                    n_phase        = PH_HDR1;
                end
            endcase

            if (w_hdr_done) begin
                n_mask_pos = 2'd0;
                n_dropping = (w_len > {48'd0, r_max_payload});
                if (w_len == 64'd0) begin
                    n_phase    = PH_HDR0;
                    n_dropping = 1'b0;
                    o_push     = 1'b1;
                    if (r_opcode == OpcClose) begin
                        o_res.event_res = EV_CLOSE;
                    end else if (r_opcode == OpcPing) begin
                        o_res.event_res = EV_EMPTY_PING;
                    end else begin
                        o_res.event_res = EV_EMPTY_DATA;
                    end
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HDR0;
            r_opcode       <= 4'd0;
            r_mask_present <= 1'b0;
            r_hdr_cnt      <= 3'd0;
            r_mask_key     <= 32'd0;
            r_mask_pos     <= 2'd0;
            r_remaining    <= 64'd0;
            r_dropping     <= 1'b0;
            r_max_payload  <= MaxPayloadReset;
        end else begin
            r_phase        <= n_phase;
            r_opcode       <= n_opcode;
            r_mask_present <= n_mask_present;
            r_hdr_cnt      <= n_hdr_cnt;
            r_mask_key     <= n_mask_key;
            r_mask_pos     <= n_mask_pos;
            r_remaining    <= n_remaining;
            r_dropping     <= n_dropping;
            if (i_cfg_valid) begin
                r_max_payload <= i_cfg_data;
            end
        end
    end

endmodule

[rtl/wsfr_queue.sv]
// ============================================================================
// wsfr_queue
// Result queue between parser and output stream; push and pop in the same
// cycle keep one beat per cycle flowing while the queue is not full.
// ============================================================================
module wsfr_queue #(
    parameter int DEPTH = wsfr_pkg::QueueDepth
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wsfr_pkg::t_result i_res,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output wsfr_pkg::t_result o_res
);
    import wsfr_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    t_result         r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count,  n_count;
    logic            w_do_push;
    logic            w_do_pop;

    assign o_full    = (r_count == FullCnt);
    assign o_valid   = (r_count != '0);
    assign o_res     = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + PtrW'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + PtrW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CntW'(1);
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[rtl/websocket_frame_receiver.sv]
// ============================================================================
// websocket_frame_receiver
// WebSocket frame parser: one received byte per beat in, unmasked payload
// bytes and frame events out.
// ============================================================================
// Takes one byte per cycle and has no idle cycles between frames. Each byte
// is parsed in the cycle it is accepted; a result it causes is written to
// the QUEUE_DEPTH-entry queue and leaves it after earlier results. The
// input stalls only while that queue is full. The maximum payload length
// is compared once per frame when its header is complete.
// ============================================================================
module websocket_frame_receiver #(
    parameter int QUEUE_DEPTH = wsfr_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,     // max_payload
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [11:8] frame_opcode
    output logic [2:0]  m_axis_tuser,   // [2:0] event_res
    output logic        m_axis_tlast    // last
);
    import wsfr_pkg::*;

    logic    w_full;
    logic    w_push;
    t_result w_push_res;
    t_result w_head;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !w_full;

    wsfr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_byte_valid (s_axis_tvalid && s_axis_tready),
        .i_byte       (s_axis_tdata),
        .o_push       (w_push),
        .o_res        (w_push_res)
    );

    wsfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res   (w_push_res),
        .o_full  (w_full),
        .i_pop   (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (w_head)
    );

    assign m_axis_tdata = {4'd0, w_head.frame_opcode, w_head.payload_byte};
    assign m_axis_tuser = w_head.event_res;
    assign m_axis_tlast = w_head.last;

endmodule
